@@ hdl/pgpf_pkg.sv @@
// ============================================================================
// Glyph pixel fetch package
// Shared types, codes and default sizes for the proportional glyph pixel
// fetch block and its submodules.
// ============================================================================
package pgpf_pkg;

    // Default sizes handed to the top level parameters.
    localparam int CHAR_CODES_DEF        = 256;
    localparam int BITMAP_BYTES_DEF      = 16384;
    localparam int MAX_GLYPH_WIDTH_DEF   = 64;
    localparam int BITMAP_ROW_PIXELS_DEF = 2048;

    // Row length register.
    localparam int              ROW_BYTES_W     = 9;
    localparam logic [8:0]      ROW_BYTES_MAX   = 9'd256;
    localparam logic [8:0]      ROW_BYTES_RESET = 9'd256;

    // Shift register width of the multiply-and-reduce sequence; it holds
    // the widest operand, a bitmap byte address.
    localparam int HV_W   = 14;
    localparam int HCNT_W = 4;

    typedef enum logic [1:0] {
        MODE_DESC_WR  = 2'd0,
        MODE_BYTE_WR  = 2'd1,
        MODE_PIXEL_QRY = 2'd2,
        MODE_LINE_QRY = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [7:0]         char_code;
        logic [7:0]         x_position;
        logic [7:0]         row;
        logic [10:0]        glyph_xpos;
        logic [6:0]         glyph_width;
        logic signed [7:0]  glyph_offset;
        logic [7:0]         glyph_advance;
        logic [13:0]        byte_address;
        logic [7:0]         byte_value;
    } in_t;

    typedef struct packed {
        logic               pixel;
        logic [5:0]         pixel_index;
        logic               last_pixel;
        logic [6:0]         char_width;
        logic signed [7:0]  char_offset;
        logic [7:0]         char_advance;
    } out_t;

    typedef struct packed {
        logic [10:0]        xpos;
        logic [6:0]         width;
        logic signed [7:0]  offset;
        logic [7:0]         advance;
    } desc_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HORNER_DBL,
        ST_HORNER_ADD,
        ST_WR_DESC,
        ST_WR_BYTE,
        ST_COL_FOLD,
        ST_COL_ADD,
        ST_FETCH,
        ST_DATA,
        ST_EMIT_ZERO
    } state_t;

endpackage

@@ hdl/pgpf_alu.sv @@
// ============================================================================
// Modular adder
// Shared arithmetic unit: adds two residues and folds the sum back below
// the modulus with one compare and subtract.
// ============================================================================
module pgpf_alu #(
    parameter int ACC_W = $clog2(pgpf_pkg::BITMAP_BYTES_DEF) + 1
) (
    input  logic [ACC_W-1:0] a,
    input  logic [ACC_W-1:0] b,
    input  logic [ACC_W-1:0] m,
    output logic [ACC_W-1:0] y
);
    import pgpf_pkg::*;

    logic [ACC_W:0] sum;
    logic [ACC_W:0] diff;

    // Operands are chosen so that the sum stays below twice the modulus.
    assign sum  = {1'b0, a} + {1'b0, b};
    assign diff = sum - {1'b0, m};
    assign y    = (sum >= {1'b0, m}) ? diff[ACC_W-1:0] : sum[ACC_W-1:0];

endmodule

@@ hdl/pgpf_desc_store.sv @@
// ============================================================================
// Glyph descriptor store
// One descriptor per character code, with a valid bit per entry so that
// unwritten and out-of-range codes read as the all-zero descriptor.
// ============================================================================
module pgpf_desc_store #(
    parameter int CHAR_CODES = pgpf_pkg::CHAR_CODES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [7:0]         wr_code,
    input  pgpf_pkg::desc_t    wr_data,
    input  logic               rd_en,
    input  logic [7:0]         rd_code,
    output pgpf_pkg::desc_t    rd_data
);
    import pgpf_pkg::*;

    localparam int CW = $clog2(CHAR_CODES);

    desc_t                  desc_mem [CHAR_CODES];
    logic [CHAR_CODES-1:0]  valid_reg;
    desc_t                  rdata_reg;
    logic                   rhit_reg;

    logic           wr_hit;
    logic           rd_hit;
    logic [CW-1:0]  wr_idx;
    logic [CW-1:0]  rd_idx;

    assign wr_hit = ({1'b0, wr_code} < 9'(CHAR_CODES));
    assign rd_hit = ({1'b0, rd_code} < 9'(CHAR_CODES));
    assign wr_idx = wr_code[CW-1:0];
    assign rd_idx = rd_code[CW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en && wr_hit) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_hit) begin
            desc_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= desc_mem[rd_idx];
            rhit_reg  <= rd_hit && valid_reg[rd_idx];
        end
    end

    assign rd_data = rhit_reg ? rdata_reg : '0;

endmodule

@@ hdl/pgpf_bitmap_mem.sv @@
// ============================================================================
// Glyph bitmap memory
// Single write port, single read port byte memory with registered read data.
// ============================================================================
module pgpf_bitmap_mem #(
    parameter int BITMAP_BYTES = pgpf_pkg::BITMAP_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [$clog2(BITMAP_BYTES)-1:0] wr_addr,
    input  logic [7:0]                      wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(BITMAP_BYTES)-1:0] rd_addr,
    output logic [7:0]                      rd_data
);
    import pgpf_pkg::*;

    logic [7:0] bitmap_mem [BITMAP_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= bitmap_mem[rd_addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

@@ hdl/proportional_glyph_pixel_fetch.sv @@
// ============================================================================
// Proportional glyph pixel fetch
// Character generator for proportional fonts: descriptor and bitmap loading,
// single pixel queries and whole glyph row queries.
// ============================================================================
// The block takes one input beat at a time and is not ready while it works
// on it. A descriptor load whose start column lies beyond the bitmap row
// first folds it back into the row, and a bitmap byte load whose address
// lies beyond the memory first wraps it. Loads and queries share the single
// modular adder: the row base address, row times row length modulo the
// memory size, is built one row bit at a time with two adder passes per bit,
// and each glyph column is then read from the bitmap memory before its pixel
// is handed over, waiting while an earlier result beat is still stalled.
// The result sits in an output register, so a finished query frees the input
// side even while its last beat waits. Descriptors for all character codes
// read as zero after reset; no clearing pass is needed.
module proportional_glyph_pixel_fetch #(
    parameter int CHAR_CODES        = pgpf_pkg::CHAR_CODES_DEF,
    parameter int BITMAP_BYTES      = pgpf_pkg::BITMAP_BYTES_DEF,
    parameter int MAX_GLYPH_WIDTH   = pgpf_pkg::MAX_GLYPH_WIDTH_DEF,
    parameter int BITMAP_ROW_PIXELS = pgpf_pkg::BITMAP_ROW_PIXELS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pgpf_pkg::in_t                    s_payload,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pgpf_pkg::out_t                   m_payload,
    input  logic                             cfg_wr_en,
    input  logic [pgpf_pkg::ROW_BYTES_W-1:0] cfg_wr_data
);
    import pgpf_pkg::*;

    // The adder works on residues of the larger of the two moduli and must
    // hold twice that value.
    localparam int MOD_MAX = (BITMAP_BYTES > BITMAP_ROW_PIXELS) ?
                             BITMAP_BYTES : BITMAP_ROW_PIXELS;
    localparam int ACC_W   = $clog2(MOD_MAX) + 1;
    localparam int AW      = $clog2(BITMAP_BYTES);
    localparam int DXW     = $clog2(MAX_GLYPH_WIDTH);

    localparam logic [ACC_W-1:0] MOD_BMP = ACC_W'(BITMAP_BYTES);
    localparam logic [ACC_W-1:0] MOD_ROW = ACC_W'(BITMAP_ROW_PIXELS);
    localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1);
    localparam logic [DXW-1:0]   DX_ONE  = DXW'(1);
    localparam logic [6:0]       WIDTH_SAT = 7'(MAX_GLYPH_WIDTH);

    localparam logic [HCNT_W-1:0] HCNT_ROW  = HCNT_W'(8);
    localparam logic [HCNT_W-1:0] HCNT_XPOS = HCNT_W'(11);
    localparam logic [HCNT_W-1:0] HCNT_ADDR = HCNT_W'(14);

    // Sequencer and datapath registers.
    state_t                  state_reg, state_next;
    in_t                     item_reg, item_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [HV_W-1:0]         hv_reg, hv_next;
    logic [HCNT_W-1:0]       hcnt_reg, hcnt_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [DXW-1:0]          dx_reg, dx_next;
    logic [2:0]              bit_reg, bit_next;
    logic [ROW_BYTES_W-1:0]  row_bytes_reg, row_bytes_next;
    logic                    m_valid_reg, m_valid_next;
    out_t                    m_payload_reg, m_payload_next;

    // Shared adder operands.
    logic [ACC_W-1:0] alu_a;
    logic [ACC_W-1:0] alu_b;
    logic [ACC_W-1:0] alu_m;
    logic [ACC_W-1:0] alu_y;

    // Memory ports.
    desc_t       desc;
    desc_t       desc_wdata;
    logic        desc_wr_en;
    logic        desc_rd_en;
    logic        bm_wr_en;
    logic        bm_rd_en;
    logic [7:0]  bm_rdata;

    logic               s_accept;
    logic               slot_free;
    logic               is_line;
    logic signed [9:0]  dx_s;
    logic               in_range;
    logic [DXW-1:0]     dx_start;
    logic [11:0]        col;
    logic               glyph_empty;
    logic               line_last;
    logic [ACC_W-1:0]   addend;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign is_line = (item_reg.mode == MODE_LINE_QRY);

    // Descriptor loads reduce the start column modulo the bitmap row, all
    // other work is modulo the bitmap memory size.
    assign alu_m  = (item_reg.mode == MODE_DESC_WR) ? MOD_ROW : MOD_BMP;
    // Queries multiply the row by the row length; loads fold an address,
    // which is the same sequence with an addend of one.
    assign addend = (item_reg.mode == MODE_PIXEL_QRY || is_line) ?
                    ACC_W'(row_bytes_reg) : ACC_ONE;

    // Column offset of a pixel query relative to the glyph's left edge.
    assign dx_s     = $signed({2'b00, item_reg.x_position})
                    - $signed({{2{desc.offset[7]}}, desc.offset});
    assign in_range = !dx_s[9] && (dx_s[8:0] < {2'b00, desc.width});
    assign dx_start = is_line ? '0 : dx_s[DXW-1:0];
    assign col      = {1'b0, desc.xpos} + 12'(dx_start);
    assign glyph_empty = is_line ? (desc.width == 7'd0) : !in_range;
    assign line_last   = ((7'(dx_reg) + 7'd1) == desc.width);

    assign desc_rd_en = s_accept && (s_payload.mode == MODE_PIXEL_QRY
                                     || s_payload.mode == MODE_LINE_QRY);

    assign desc_wdata.xpos    = 11'(acc_reg);
    assign desc_wdata.width   = (item_reg.glyph_width > WIDTH_SAT) ?
                                WIDTH_SAT : item_reg.glyph_width;
    assign desc_wdata.offset  = item_reg.glyph_offset;
    assign desc_wdata.advance = item_reg.glyph_advance;

    pgpf_alu #(
        .ACC_W (ACC_W)
    ) u_alu (
        .a (alu_a),
        .b (alu_b),
        .m (alu_m),
        .y (alu_y)
    );

    pgpf_desc_store #(
        .CHAR_CODES (CHAR_CODES)
    ) u_desc_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (desc_wr_en),
        .wr_code (item_reg.char_code),
        .wr_data (desc_wdata),
        .rd_en   (desc_rd_en),
        .rd_code (s_payload.char_code),
        .rd_data (desc)
    );

    pgpf_bitmap_mem #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_bitmap_mem (
        .aclk    (aclk),
        .wr_en   (bm_wr_en),
        .wr_addr (acc_reg[AW-1:0]),
        .wr_data (item_reg.byte_value),
        .rd_en   (bm_rd_en),
        .rd_addr (addr_reg),
        .rd_data (bm_rdata)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            row_bytes_reg <= ROW_BYTES_RESET;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            row_bytes_reg <= row_bytes_next;
        end
    end

    // Datapath state.
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        acc_reg       <= acc_next;
        hv_reg        <= hv_next;
        hcnt_reg      <= hcnt_next;
        addr_reg      <= addr_next;
        dx_reg        <= dx_next;
        bit_reg       <= bit_next;
        m_payload_reg <= m_payload_next;
    end

    // Row length is saturated on the way in.
    always_comb begin
        row_bytes_next = row_bytes_reg;
        if (cfg_wr_en) begin
            row_bytes_next = (cfg_wr_data > ROW_BYTES_MAX) ? ROW_BYTES_MAX : cfg_wr_data;
        end
    end

    always_comb begin
        state_next     = state_reg;
        item_next      = s_accept ? s_payload : item_reg;
        acc_next       = acc_reg;
        hv_next        = hv_reg;
        hcnt_next      = hcnt_reg;
        addr_next      = addr_reg;
        dx_next        = dx_reg;
        bit_next       = bit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        alu_a          = acc_reg;
        alu_b          = acc_reg;
        desc_wr_en     = 1'b0;
        bm_wr_en       = 1'b0;
        bm_rd_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    acc_next = '0;
                    unique case (s_payload.mode)
                        MODE_DESC_WR: begin
                            hv_next   = {s_payload.glyph_xpos, 3'b000};
                            hcnt_next = HCNT_XPOS;
                            if (32'(s_payload.glyph_xpos) < BITMAP_ROW_PIXELS) begin
                                acc_next   = ACC_W'(s_payload.glyph_xpos);
                                state_next = ST_WR_DESC;
                            end else begin
                                state_next = ST_HORNER_DBL;
                            end
                        end
                        MODE_BYTE_WR: begin
                            hv_next   = s_payload.byte_address;
                            hcnt_next = HCNT_ADDR;
                            if (32'(s_payload.byte_address) < BITMAP_BYTES) begin
                                acc_next   = ACC_W'(s_payload.byte_address);
                                state_next = ST_WR_BYTE;
                            end else begin
                                state_next = ST_HORNER_DBL;
                            end
                        end
                        MODE_PIXEL_QRY, MODE_LINE_QRY: begin
                            hv_next    = {s_payload.row, 6'b000000};
                            hcnt_next  = HCNT_ROW;
                            state_next = ST_HORNER_DBL;
                        end
                    endcase
                end
            end
            // Double the running residue.
            ST_HORNER_DBL: begin
                acc_next   = alu_y;
                state_next = ST_HORNER_ADD;
            end
            // Add the addend where the current operand bit is set.
            ST_HORNER_ADD: begin
                alu_b     = hv_reg[HV_W-1] ? addend : '0;
                acc_next  = alu_y;
                hv_next   = hv_reg << 1;
                hcnt_next = hcnt_reg - HCNT_W'(1);
                if (hcnt_reg == HCNT_W'(1)) begin
                    priority if (item_reg.mode == MODE_DESC_WR) begin
                        state_next = ST_WR_DESC;
                    end else if (item_reg.mode == MODE_BYTE_WR) begin
                        state_next = ST_WR_BYTE;
                    end else begin
                        state_next = ST_COL_FOLD;
                    end
                end else begin
                    state_next = ST_HORNER_DBL;
                end
            end
            ST_WR_DESC: begin
                desc_wr_en = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WR_BYTE: begin
                bm_wr_en   = 1'b1;
                state_next = ST_IDLE;
            end
            // Fold the first column's byte index below the memory size.
            ST_COL_FOLD: begin
                alu_a      = '0;
                alu_b      = ACC_W'(col[11:3]);
                addr_next  = alu_y[AW-1:0];
                dx_next    = dx_start;
                bit_next   = col[2:0];
                state_next = glyph_empty ? ST_EMIT_ZERO : ST_COL_ADD;
            end
            // Add the row base, held in the accumulator.
            ST_COL_ADD: begin
                alu_b      = ACC_W'(addr_reg);
                addr_next  = alu_y[AW-1:0];
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                bm_rd_en   = 1'b1;
                state_next = ST_DATA;
            end
            ST_DATA: begin
                alu_a = ACC_W'(addr_reg);
                alu_b = ACC_ONE;
                if (slot_free) begin
                    m_valid_next                = 1'b1;
                    m_payload_next.pixel        = bm_rdata[~bit_reg];
                    m_payload_next.pixel_index  = is_line ? 6'(dx_reg) : 6'd0;
                    m_payload_next.last_pixel   = !is_line || line_last;
                    m_payload_next.char_width   = desc.width;
                    m_payload_next.char_offset  = desc.offset;
                    m_payload_next.char_advance = desc.advance;
                    if (!is_line || line_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        dx_next  = dx_reg + DX_ONE;
                        bit_next = bit_reg + 3'd1;
                        if (bit_reg == 3'd7) begin
                            addr_next = alu_y[AW-1:0];
                        end
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_EMIT_ZERO: begin
                if (slot_free) begin
                    m_valid_next                = 1'b1;
                    m_payload_next.pixel        = 1'b0;
                    m_payload_next.pixel_index  = 6'd0;
                    m_payload_next.last_pixel   = 1'b1;
                    m_payload_next.char_width   = desc.width;
                    m_payload_next.char_offset  = desc.offset;
                    m_payload_next.char_advance = desc.advance;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/pgpf_checker.sv @@
// ============================================================================
// Glyph pixel fetch port checker
// Assertions on the top level ports, attached to it by a bind statement.
// ============================================================================
module pgpf_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input pgpf_pkg::in_t   s_payload,
    input logic            m_valid,
    input logic            m_ready,
    input pgpf_pkg::out_t  m_payload
);
    import pgpf_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result beat changed while stalled");

    // Accepting an input beat always takes the block out of idle, so ready drops.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // While a line is still being delivered no new input is taken.
    a_line_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.last_pixel |-> !s_ready)
        else $error("input ready in the middle of a line");

    // A beat that is not the last lies strictly inside the glyph.
    a_index_in_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.last_pixel
            |-> (({1'b0, m_payload.pixel_index} + 7'd1) < m_payload.char_width))
        else $error("line beat outside glyph width");

    // A set pixel needs a glyph of nonzero width.
    a_pixel_needs_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.pixel |-> m_payload.char_width != 7'd0)
        else $error("set pixel reported for empty glyph");

endmodule

bind proportional_glyph_pixel_fetch pgpf_checker u_pgpf_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Proportional glyph pixel fetch testbench
// Loads glyph descriptors and bitmap bytes, then runs pixel and line queries.
// A short directed table comes first, then about 460 random beats in several
// idling phases, each with its own row length. Every result beat is checked
// field by field against an in-bench glyph predictor or a typed row's value.
// ============================================================================
module tb;
    import pgpf_pkg::*;

    localparam int CHAR_CODES    = CHAR_CODES_DEF;
    localparam int BITMAP_BYTES  = BITMAP_BYTES_DEF;
    localparam int MAX_WIDTH     = MAX_GLYPH_WIDTH_DEF;
    localparam int ROW_PIXELS    = BITMAP_ROW_PIXELS_DEF;
    localparam int PHASES        = 5;
    localparam int BEATS_PER_PHASE = 92;
    // The slowest load is a bitmap write that wraps. Wait comfortably longer
    // than it takes before a register write or the end.
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 2000000;

    logic   aclk        = 1'b0;
    logic   aresetn     = 1'b0;
    logic   s_valid     = 1'b0;
    logic   s_ready;
    in_t    s_payload   = '0;
    logic   m_valid;
    logic   m_ready     = 1'b0;
    out_t   m_payload;
    logic   cfg_wr_en   = 1'b0;
    logic [ROW_BYTES_W-1:0] cfg_wr_data = '0;

    // Glyph predictor state: descriptors, bitmap bytes and which of them
    // have been written, and the effective row length.
    desc_t       desc_tab   [CHAR_CODES];
    logic [7:0]  glyph_mem  [BITMAP_BYTES];
    bit          byte_known [BITMAP_BYTES];
    int unsigned row_len = 256;

    // Result beats still owed by the block, oldest first.
    out_t pending_pixels [$];

    typedef struct {
        in_t  beat;
        bit   typed;
        out_t want;
    } steer_row_t;
    steer_row_t steer_tab [$];

    int   sender_idle_pct = 0;
    int   stall_pct       = 0;
    int   beats_sent      = 0;
    int   mismatches      = 0;
    int   cycles          = 0;
    out_t head_pixel;

    // Clock, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    proportional_glyph_pixel_fetch i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Receiver: ready is redrawn at every falling edge from the stall rate
    // of the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("proportional_glyph_pixel_fetch verification failed");
            $finish;
        end
    end

    // Result checker: every accepted beat is matched to the oldest
    // expectation, one field at a time.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: pix %0d idx %0d last %0d w %0d off %0d adv %0d",
                             m_payload.pixel, m_payload.pixel_index, m_payload.last_pixel,
                             m_payload.char_width, m_payload.char_offset,
                             m_payload.char_advance);
            end else begin
                head_pixel = pending_pixels.pop_front();
                if (m_payload.pixel        !== head_pixel.pixel        ||
                    m_payload.pixel_index  !== head_pixel.pixel_index  ||
                    m_payload.last_pixel   !== head_pixel.last_pixel   ||
                    m_payload.char_width   !== head_pixel.char_width   ||
                    m_payload.char_offset  !== head_pixel.char_offset  ||
                    m_payload.char_advance !== head_pixel.char_advance) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("result mismatch: expected pix %0d idx %0d last %0d w %0d",
                               head_pixel.pixel, head_pixel.pixel_index,
                               head_pixel.last_pixel, head_pixel.char_width);
                        $write(" off %0d adv %0d, ",
                               head_pixel.char_offset, head_pixel.char_advance);
                        $display("got pix %0d idx %0d last %0d w %0d off %0d adv %0d",
                                 m_payload.pixel, m_payload.pixel_index,
                                 m_payload.last_pixel, m_payload.char_width,
                                 m_payload.char_offset, m_payload.char_advance);
                    end
                end
            end
        end
    end

    // Byte address of glyph column dx on scan line r; rows past the end of
    // the memory wrap around.
    function automatic int unsigned glyph_byte_addr(desc_t d, int unsigned dx, logic [7:0] r);
        int unsigned col;
        col = int'(d.xpos) + dx;
        return ((col >> 3) + int'(r) * row_len) % BITMAP_BYTES;
    endfunction

    // Pixel at glyph column dx; the leftmost pixel of a byte is bit 7.
    function automatic logic glyph_bit(desc_t d, int unsigned dx, logic [7:0] r);
        int unsigned col;
        col = int'(d.xpos) + dx;
        return glyph_mem[glyph_byte_addr(d, dx, r)][7 - (col % 8)];
    endfunction

    // Apply one accepted beat to the predictor and queue the result beats
    // it owes. A typed row replaces the prediction with its written value.
    function automatic void glyph_predict(in_t b, bit typed, out_t want);
        desc_t       d;
        desc_t       nd;
        out_t        r;
        int          dx;
        int unsigned a;
        d = desc_tab[b.char_code];
        r = '0;
        r.last_pixel   = 1'b1;
        r.char_width   = d.width;
        r.char_offset  = d.offset;
        r.char_advance = d.advance;
        case (b.mode)
            MODE_DESC_WR: begin
                nd.xpos    = 11'(b.glyph_xpos % ROW_PIXELS);
                nd.width   = (b.glyph_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : b.glyph_width;
                nd.offset  = b.glyph_offset;
                nd.advance = b.glyph_advance;
                desc_tab[b.char_code] = nd;
            end
            MODE_BYTE_WR: begin
                a = b.byte_address % BITMAP_BYTES;
                glyph_mem[a]  = b.byte_value;
                byte_known[a] = 1'b1;
            end
            MODE_PIXEL_QRY: begin
                dx = int'(b.x_position) - int'(d.offset);
                if (dx >= 0 && dx < int'(d.width))
                    r.pixel = glyph_bit(d, dx, b.row);
                pending_pixels.push_back(typed ? want : r);
            end
            default: begin
                if (typed) begin
                    pending_pixels.push_back(want);
                end else if (d.width == 0) begin
                    // Empty glyph: a single blank beat that closes the line.
                    pending_pixels.push_back(r);
                end else begin
                    for (int i = 0; i < int'(d.width); i++) begin
                        r.pixel       = glyph_bit(d, i, b.row);
                        r.pixel_index = 6'(i);
                        r.last_pixel  = (i == int'(d.width) - 1);
                        pending_pixels.push_back(r);
                    end
                end
            end
        endcase
    endfunction

    function automatic in_t rand_beat();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(in_t)-1:0];
    endfunction

    // Drive one input beat and hold it until it is taken. Called and
    // returning at a falling edge.
    task automatic send_beat(in_t b, bit typed, out_t want);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        glyph_predict(b, typed, want);
        beats_sent++;
        @(negedge aclk);
    endtask

    // A query must only read bitmap bytes that were written, so any byte it
    // would touch that is still unknown gets a random write first. A pixel
    // query outside the glyph reads nothing.
    task automatic cover_reads(in_t b);
        desc_t       d;
        int          lo;
        int          hi;
        int unsigned a;
        in_t         fill;
        d  = desc_tab[b.char_code];
        lo = 0;
        hi = int'(d.width) - 1;
        if (b.mode == MODE_PIXEL_QRY) begin
            lo = int'(b.x_position) - int'(d.offset);
            hi = lo;
            if (lo < 0 || lo >= int'(d.width)) begin
                lo = 0;
                hi = -1;
            end
        end
        if (b.mode == MODE_PIXEL_QRY || b.mode == MODE_LINE_QRY) begin
            for (int dx = lo; dx <= hi; dx++) begin
                a = glyph_byte_addr(d, dx, b.row);
                if (!byte_known[a]) begin
                    fill = rand_beat();
                    fill.mode = MODE_BYTE_WR;
                    fill.byte_address = 14'(a);
                    send_beat(fill, 1'b0, '0);
                end
            end
        end
    endtask

    // Hold the sender off until every owed result beat has arrived.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_pixels.size() != 0) @(negedge aclk);
    endtask

    // Row length writes happen only with the block idle; loads give no
    // result, so a settle period follows the drain.
    task automatic set_row_bytes(logic [ROW_BYTES_W-1:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        row_len = (v > ROW_BYTES_MAX) ? 256 : int'(v);
    endtask

    // Random query on a code, with x steered into or just beside the glyph most of the time.
    task automatic ask_glyph(logic [7:0] code);
        in_t   b;
        desc_t d;
        d = desc_tab[code];
        b = rand_beat();
        b.char_code = code;
        b.mode = $urandom_range(1) ? MODE_LINE_QRY : MODE_PIXEL_QRY;
        if ($urandom_range(3) != 0)
            b.row = 8'($urandom_range(7));
        if ($urandom_range(3) != 0)
            b.x_position = 8'(int'(d.offset) + int'($urandom_range(int'(d.width) + 1)) - 1);
        cover_reads(b);
        send_beat(b, 1'b0, '0);
    endtask

    function automatic in_t query(mode_t m, int code, int x, int r);
        in_t b;
        b = '0;
        b.mode       = m;
        b.char_code  = 8'(code);
        b.x_position = 8'(x);
        b.row        = 8'(r);
        return b;
    endfunction

    function automatic in_t desc_load(int code, int xpos, int w, int off, int adv);
        in_t b;
        b = '0;
        b.mode          = MODE_DESC_WR;
        b.char_code     = 8'(code);
        b.glyph_xpos    = 11'(xpos);
        b.glyph_width   = 7'(w);
        b.glyph_offset  = 8'(off);
        b.glyph_advance = 8'(adv);
        return b;
    endfunction

    function automatic in_t byte_load(int addr, int val);
        in_t b;
        b = '0;
        b.mode         = MODE_BYTE_WR;
        b.byte_address = 14'(addr);
        b.byte_value   = 8'(val);
        return b;
    endfunction

    // Single-beat result that can be read straight off the descriptor.
    function automatic out_t lone_pixel(int pix, int w, int off, int adv);
        out_t r;
        r = '0;
        r.pixel        = pix[0];
        r.last_pixel   = 1'b1;
        r.char_width   = 7'(w);
        r.char_offset  = 8'(off);
        r.char_advance = 8'(adv);
        return r;
    endfunction

    function automatic void plan(in_t b);
        steer_tab.push_back('{b, 1'b0, '0});
    endfunction

    function automatic void plan_typed(in_t b, out_t w);
        steer_tab.push_back('{b, 1'b1, w});
    endfunction

    initial begin
        int          idle_of  [PHASES];
        int          stall_of [PHASES];
        int          rowb_of  [PHASES];
        int          roll;
        int          goal;
        logic [7:0]  code;
        in_t         b;
        idle_of  = '{0, 77, 0, 14, 0};
        stall_of = '{0, 0, 77, 14, 0};
        rowb_of  = '{1, 0, 256, 2 + $urandom_range(253), 300};
        foreach (desc_tab[i]) desc_tab[i] = '0;

        // Directed part. Descriptors read as zero after reset, so the first
        // queries give a blank beat; later rows cover the signed offset, a
        // saturated width, an empty glyph, a one-pixel glyph and reads that
        // wrap past the end of the bitmap.
        plan_typed(query(MODE_PIXEL_QRY, 0, 0, 0), lone_pixel(0, 0, 0, 0));
        plan_typed(query(MODE_LINE_QRY, 255, 0, 255), lone_pixel(0, 0, 0, 0));
        plan(desc_load(0, 0, 8, 0, 8));
        plan(byte_load(0, 8'hA5));
        plan_typed(query(MODE_PIXEL_QRY, 0, 0, 0), lone_pixel(1, 8, 0, 8));
        plan_typed(query(MODE_PIXEL_QRY, 0, 1, 0), lone_pixel(0, 8, 0, 8));
        plan(query(MODE_LINE_QRY, 0, 0, 0));
        plan(byte_load(16383, 8'hFF));
        plan(desc_load(255, 2047, 127, -128, 255));
        plan(query(MODE_LINE_QRY, 255, 0, 255));
        plan_typed(query(MODE_PIXEL_QRY, 255, 255, 255), lone_pixel(0, 64, -128, 255));
        plan(desc_load(1, 1000, 64, 127, 0));
        plan_typed(query(MODE_PIXEL_QRY, 1, 126, 3), lone_pixel(0, 64, 127, 0));
        plan(query(MODE_PIXEL_QRY, 1, 127, 3));
        plan(query(MODE_PIXEL_QRY, 1, 190, 3));
        plan_typed(query(MODE_PIXEL_QRY, 1, 191, 3), lone_pixel(0, 64, 127, 0));
        plan(desc_load(2, 5, 0, -1, 3));
        plan_typed(query(MODE_LINE_QRY, 2, 0, 0), lone_pixel(0, 0, -1, 3));
        plan_typed(query(MODE_PIXEL_QRY, 2, 255, 0), lone_pixel(0, 0, -1, 3));
        plan(desc_load(3, 12, 1, 0, 1));
        plan(query(MODE_LINE_QRY, 3, 0, 1));
        plan(desc_load(4, 100, 65, -5, 200));
        plan(query(MODE_LINE_QRY, 4, 0, 7));
        plan(byte_load(8191, 8'h00));
        plan(query(MODE_PIXEL_QRY, 4, 0, 0));

        // Synchronous reset, then a row length above the maximum, which the block
        // saturates.
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_row_bytes(9'd511);

        foreach (steer_tab[i]) begin
            cover_reads(steer_tab[i].beat);
            send_beat(steer_tab[i].beat, steer_tab[i].typed, steer_tab[i].want);
        end

        // Random part, one row length and idling profile per phase.
        beats_sent = 0;
        for (int p = 0; p < PHASES; p++) begin
            sender_idle_pct = 0;
            stall_pct       = 0;
            set_row_bytes(9'(rowb_of[p]));
            sender_idle_pct = idle_of[p];
            stall_pct       = stall_of[p];
            goal = (p + 1) * BEATS_PER_PHASE;
            while (beats_sent < goal) begin
                roll = $urandom_range(99);
                // Now and then the sender waits for the block to empty out.
                if (roll < 3)
                    drain_results();
                code = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(15));
                if (roll < 40) begin
                    // A fresh glyph followed by a few queries on it.
                    b = rand_beat();
                    b.mode = MODE_DESC_WR;
                    b.char_code = code;
                    b.glyph_width = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                             : 7'($urandom_range(16));
                    if ($urandom_range(3) != 0)
                        b.glyph_xpos = 11'($urandom_range(255));
                    send_beat(b, 1'b0, '0);
                    repeat (1 + $urandom_range(2)) ask_glyph(code);
                end else if (roll < 80) begin
                    ask_glyph(code);
                end else if (roll < 92) begin
                    b = rand_beat();
                    b.mode = MODE_BYTE_WR;
                    send_beat(b, 1'b0, '0);
                end else begin
                    b = rand_beat();
                    b.mode = MODE_DESC_WR;
                    send_beat(b, 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("proportional_glyph_pixel_fetch verification clean");
        end else begin
            $display("proportional_glyph_pixel_fetch verification failed");
        end
        $finish;
    end

endmodule
